// File: rtl/core/bpcd_pkg.sv
package bpcd_pkg;

   localparam int BYTE_W              = 8;
   localparam int CFG_W               = 12;
   localparam int LEN_W               = 31;
   localparam int HDR_BYTES           = 4;
   localparam int DIGEST_BYTES        = 16;
   localparam int DIGEST_BIT          = 7;
   localparam int HCNT_W              = $clog2(DIGEST_BYTES);
   localparam int BLOCK_BYTES_DEFAULT = 4096;
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_DIGEST  = 2'd1,
      PH_PAYLOAD = 2'd2
   } bpcd_phase_type;

   // one byte moving between front, queue and back
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } bpcd_beat_type;

endpackage

// File: rtl/core/bpcd_front.sv
module bpcd_front
   import bpcd_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [BYTE_W-1:0] req_raw_byte,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_start_block_offset,
   input  logic             q_ready,
   output bpcd_beat_type    q_beat
);

   localparam int     POS_W     = $clog2(BLOCK_BYTES);
   // floor(off / BLOCK_BYTES) = (off * RCP_M) >> RCP_S, exact for any 12-bit offset
   localparam int     RCP_S     = CFG_W + POS_W;
   localparam int     RCP_W     = CFG_W + 2;
   localparam longint RCP_M     = ((longint'(1) << RCP_S) + BLOCK_BYTES - 1) / BLOCK_BYTES;
   localparam int     PROD_W    = CFG_W + RCP_W;
   localparam int     RED_STEPS = 2;
   localparam int     STEP_W    = 2;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [STEP_W-1:0] red_cnt_ff, red_cnt_in;
   logic [CFG_W-1:0]  off_ff, off_in, quo_ff, quo_in, red_sub;
   logic [RCP_W-1:0]  rcp;
   logic [PROD_W-1:0] prod;
   logic              busy, accept;

   assign busy      = (red_cnt_ff != '0);
   // a pending csr write goes first
   assign req_ready = !busy && q_ready && !csr_valid;
   assign csr_ready = !busy;
   assign accept    = req_valid && req_ready;

   // step one: quotient by reciprocal, step two: subtract
   assign rcp     = RCP_W'(RCP_M);
   assign prod    = {{RCP_W{1'b0}}, off_ff} * {{CFG_W{1'b0}}, rcp};
   assign red_sub = CFG_W'(quo_ff * CFG_W'(BLOCK_BYTES));

   always_comb begin
      pos_in     = pos_ff;
      red_cnt_in = red_cnt_ff;
      off_in     = off_ff;
      quo_in     = quo_ff;
      if (csr_valid && csr_ready) begin
         red_cnt_in = STEP_W'(RED_STEPS);
         off_in     = csr_start_block_offset;
      end else if (busy) begin
         red_cnt_in = red_cnt_ff - 1'b1;
         if (red_cnt_ff == STEP_W'(RED_STEPS)) begin
            quo_in = CFG_W'(prod >> RCP_S);
         end else begin
            pos_in = POS_W'(off_ff - red_sub);
         end
      end else if (accept) begin
         pos_in = (pos_ff == POS_W'(BLOCK_BYTES - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   // byte at block position zero is a marker and never reaches the queue
   always_comb begin
      q_beat.valid = accept && (pos_ff != '0);
      q_beat.data  = req_raw_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         red_cnt_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         red_cnt_ff <= red_cnt_in;
      end
      off_ff <= off_in;
      quo_ff <= quo_in;
   end

endmodule

// File: rtl/core/bpcd_queue.sv
module bpcd_queue
   import bpcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  bpcd_beat_type push_beat,
   output logic          push_ready,
   output bpcd_beat_type pop_beat,
   input  logic          pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [BYTE_W-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready     = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign do_push        = push_beat.valid && push_ready;
   assign pop_beat.valid = (cnt_ff != '0);
   assign pop_beat.data  = mem[rd_ptr_ff];
   assign do_pop         = pop_beat.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_beat.data;
      end
   end

endmodule

// File: rtl/core/bpcd_back.sv
module bpcd_back
   import bpcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  bpcd_beat_type     q_beat,
   output logic              q_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic              rsp_first_flag,
   output logic              rsp_last_flag,
   output logic              rsp_digest_present,
   output logic              rsp_empty_chunk
);

   bpcd_phase_type    phase_ff, phase_in;
   logic [HCNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]  len_ff, len_in, rem_ff, rem_in, len_new, fin_len;
   logic              digest_ff, digest_in, first_ff, first_in;
   logic              take, hdr_done, dig_done, finish, fin_empty;
   logic              res_v;
   logic [BYTE_W-1:0] res_byte;
   logic              res_first, res_last, res_empty;

   logic              ov_ff, ov_in;
   logic [BYTE_W-1:0] ob_ff;
   logic              of_ff, ol_ff, od_ff, oe_ff;

   assign q_ready = !ov_ff || rsp_ready;
   assign take    = q_beat.valid && q_ready;

   assign len_new  = (cnt_ff == '0) ? LEN_W'(q_beat.data[DIGEST_BIT-1:0])
                                     : {len_ff[LEN_W-BYTE_W-1:0], q_beat.data};
   assign hdr_done = (cnt_ff == HCNT_W'(HDR_BYTES - 1));
   assign dig_done = (cnt_ff == HCNT_W'(DIGEST_BYTES - 1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_PAYLOAD: if (rem_ff == LEN_W'(1)) phase_in = PH_HEADER;
            PH_DIGEST:  if (dig_done) phase_in = (len_ff == '0) ? PH_HEADER : PH_PAYLOAD;
            default: begin
               if (phase_ff == PH_HEADER && hdr_done) begin
                  if (digest_in)            phase_in = PH_DIGEST;
                  else if (len_new == '0)   phase_in = PH_HEADER;
                  else                      phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      digest_in = digest_ff;
      first_in  = first_ff;
      finish    = 1'b0;
      fin_len   = len_ff;
      res_v     = 1'b0;
      res_byte  = q_beat.data;
      res_first = first_ff;
      res_last  = 1'b0;
      res_empty = 1'b0;
      if (take) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               rem_in   = rem_ff - 1'b1;
               res_v    = 1'b1;
               res_last = (rem_ff == LEN_W'(1));
               first_in = res_last;
               cnt_in   = '0;
            end
            PH_DIGEST: begin
               cnt_in = cnt_ff + 1'b1;
               if (dig_done) begin
                  finish = 1'b1;
               end
            end
            default: begin
               // a leftover count from an odd phase restarts the header
               if (phase_ff != PH_HEADER || cnt_ff >= HCNT_W'(HDR_BYTES)) begin
                  cnt_in = HCNT_W'(1);
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (phase_ff != PH_HEADER || cnt_ff == '0 || cnt_ff >= HCNT_W'(HDR_BYTES)) begin
                  digest_in = q_beat.data[DIGEST_BIT];
                  len_in    = LEN_W'(q_beat.data[DIGEST_BIT-1:0]);
               end else begin
                  len_in    = len_new;
               end
               fin_len = len_in;
               if (phase_ff == PH_HEADER && hdr_done) begin
                  cnt_in = '0;
                  finish = !digest_in;
               end
            end
         endcase
         if (finish) begin
            cnt_in   = '0;
            first_in = 1'b1;
            rem_in   = fin_len;
            if (fin_len == '0) begin
               res_v     = 1'b1;
               res_byte  = '0;
               res_first = 1'b1;
               res_last  = 1'b1;
               res_empty = 1'b1;
            end
         end
      end
      fin_empty = finish && (fin_len == '0);
   end

   assign ov_in = take ? res_v : (ov_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         cnt_ff    <= '0;
         len_ff    <= '0;
         rem_ff    <= '0;
         digest_ff <= 1'b0;
         first_ff  <= 1'b1;
         ov_ff     <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
         rem_ff    <= rem_in;
         digest_ff <= digest_in;
         first_ff  <= first_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_v) begin
         ob_ff <= res_byte;
         of_ff <= res_first;
         ol_ff <= res_last;
         od_ff <= digest_in;
         oe_ff <= res_empty && fin_empty;
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_payload_byte   = ob_ff;
   assign rsp_first_flag     = of_ff;
   assign rsp_last_flag      = ol_ff;
   assign rsp_digest_present = od_ff;
   assign rsp_empty_chunk    = oe_ff;

endmodule

// File: rtl/core/block_prefixed_chunk_deframer_core.sv
// Chunk deframer for block-structured files. Raw file bytes enter on the req_
// channel, one request per cycle while req_ready is high. The block position
// counts bytes modulo BLOCK_BYTES from the offset held in the csr_ register;
// each byte that lands on block position zero is a marker and is dropped. The
// rest are parsed as chunks: a 4-byte big-endian header (top bit announces a
// 16-byte digest, which is skipped unchecked, low 31 bits the payload length),
// then the payload bytes, each given out on rsp_ with first/last marks. A
// zero-length chunk gives one response with rsp_empty_chunk set and a zero
// byte. The front end (position counter, marker drop) feeds a four-entry
// queue, and the back end (header parser, response register) drains it; a
// payload byte taken from req_ passes through a queue entry and the response
// register before it shows on rsp_, and with rsp_ready held high and no csr
// write the block sustains one byte per cycle. A csr write reduces the offset
// modulo BLOCK_BYTES by a reciprocal multiply, then a subtract, while req_ready
// and csr_ready stay low; req_ready is also low while csr_valid is high.
module block_prefixed_chunk_deframer_core
   import bpcd_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_raw_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic              rsp_first_flag,
   output logic              rsp_last_flag,
   output logic              rsp_digest_present,
   output logic              rsp_empty_chunk,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_start_block_offset
);

   bpcd_beat_type front_beat, back_beat;
   logic          front_q_ready, back_q_ready;

   // front: block position and marker removal
   bpcd_front #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_raw_byte           (req_raw_byte),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_start_block_offset (csr_start_block_offset),
      .q_ready                (front_q_ready),
      .q_beat                 (front_beat)
   );

   // decoupling queue, lets either side stall alone
   bpcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_beat  (front_beat),
      .push_ready (front_q_ready),
      .pop_beat   (back_beat),
      .pop_ready  (back_q_ready)
   );

   // back: header/digest parse and response register
   bpcd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_beat             (back_beat),
      .q_ready            (back_q_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_first_flag     (rsp_first_flag),
      .rsp_last_flag      (rsp_last_flag),
      .rsp_digest_present (rsp_digest_present),
      .rsp_empty_chunk    (rsp_empty_chunk)
   );

   // an empty chunk response always carries both marks and a zero byte
   a_empty_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_chunk |->
         rsp_first_flag && rsp_last_flag && (rsp_payload_byte == '0))
      else $error("empty chunk response malformed");

   // offset reduction blocks requests right after a csr write
   a_cfg_blocks : assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready && !csr_ready)
      else $error("request accepted during offset reduction");

   // nothing reaches the queue unless a request was taken
   a_push_src : assert property (@(posedge clock) disable iff (reset)
      front_beat.valid |-> req_valid && req_ready)
      else $error("queue push without request");

endmodule
